[hw/rtl/tsc_pkg.sv]
// types, codes and helpers shared by the token scanner modules
package tsc_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;
    localparam int MAX_RESULTS = 4;
    localparam int CAND_COUNT  = 5;
    localparam int CNT_BITS    = $clog2(MAX_RESULTS + 1);
    localparam int IDX_BITS    = $clog2(MAX_RESULTS);

    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    // token kinds
    localparam logic [3:0] KIND_EOF       = 4'd0;
    localparam logic [3:0] KIND_DIRECTIVE = 4'd1;
    localparam logic [3:0] KIND_PUNCT     = 4'd2;
    localparam logic [3:0] KIND_IDENT     = 4'd3;
    localparam logic [3:0] KIND_NUMBER    = 4'd4;
    localparam logic [3:0] KIND_STRING    = 4'd5;
    localparam logic [3:0] KIND_CHAR      = 4'd6;
    localparam logic [3:0] KIND_HEADER    = 4'd7;
    localparam logic [3:0] KIND_ERROR     = 4'd8;

    // error codes
    localparam logic [3:0] ERR_NONE          = 4'd0;
    localparam logic [3:0] ERR_BAD_ESCAPE    = 4'd1;
    localparam logic [3:0] ERR_EOF_STRING    = 4'd2;
    localparam logic [3:0] ERR_EOF_CHAR      = 4'd3;
    localparam logic [3:0] ERR_OPEN_STRING   = 4'd4;
    localparam logic [3:0] ERR_OPEN_CHAR     = 4'd5;
    localparam logic [3:0] ERR_EOF_HEADER    = 4'd6;
    localparam logic [3:0] ERR_EOL_HEADER    = 4'd7;
    localparam logic [3:0] ERR_AFTER_HEADER  = 4'd8;
    localparam logic [3:0] ERR_NO_HEADER     = 4'd9;

    // scanner modes
    localparam logic [3:0] MODE_IDLE      = 4'd0;
    localparam logic [3:0] MODE_IDENT     = 4'd1;
    localparam logic [3:0] MODE_NUMBER    = 4'd2;
    localparam logic [3:0] MODE_SLASH     = 4'd3;
    localparam logic [3:0] MODE_LINE_CMT  = 4'd4;
    localparam logic [3:0] MODE_BLOCK_CMT = 4'd5;
    localparam logic [3:0] MODE_HASH      = 4'd6;
    localparam logic [3:0] MODE_DIRECTIVE = 4'd7;
    localparam logic [3:0] MODE_QUOTE     = 4'd8;
    localparam logic [3:0] MODE_HDR_WAIT  = 4'd9;
    localparam logic [3:0] MODE_HDR_BODY  = 4'd10;
    localparam logic [3:0] MODE_HDR_TAIL  = 4'd11;
    localparam logic [3:0] MODE_SKIP_AFTER = 4'd12;
    localparam logic [3:0] MODE_SKIP_NONE = 4'd13;

    localparam logic [3:0] MATCH_FAIL = 4'd15;
    localparam logic [3:0] MATCH_DONE = 4'd7;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_US    = 8'h5F;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [3:0]             token_kind;
        logic [3:0]             error_code;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] end_offset;
        logic [LINE_BITS-1:0]   line_number;
        logic [COLUMN_BITS-1:0] column_number;
        logic                   run_last;
    } out_item_t;

    typedef struct packed {
        logic [3:0]             mode;
        logic                   include_mode;
        logic [3:0]             dir_match;
        logic                   quote_dbl;
        logic                   esc_pend;
        logic                   star_seen;
        logic [OFFSET_BITS-1:0] offset;
        logic [LINE_BITS-1:0]   line;
        logic [COLUMN_BITS-1:0] column;
        logic [OFFSET_BITS-1:0] tok_off;
        logic [LINE_BITS-1:0]   tok_line;
        logic [COLUMN_BITS-1:0] tok_col;
        logic [OFFSET_BITS-1:0] hdr_end;
    } scan_state_t;

    function automatic scan_state_t reset_state();
        scan_state_t s;
        s = '0;
        s.mode     = MODE_IDLE;
        s.line     = LINE_BITS'(1);
        s.column   = COLUMN_BITS'(1);
        s.tok_line = LINE_BITS'(1);
        s.tok_col  = COLUMN_BITS'(1);
        return s;
    endfunction

    function automatic logic [7:0] include_char(input logic [3:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h69;
            4'd1:    ch = 8'h6E;
            4'd2:    ch = 8'h63;
            4'd3:    ch = 8'h6C;
            4'd4:    ch = 8'h75;
            4'd5:    ch = 8'h64;
            4'd6:    ch = 8'h65;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

[hw/rtl/tsc_scan.sv]
// combinational scanner step: state and one byte in, next state and results out
module tsc_scan import tsc_pkg::*; (
    input  scan_state_t              cur_state,
    input  in_item_t                 item,
    output scan_state_t              nxt_state,
    output out_item_t                res [MAX_RESULTS],
    output logic [CNT_BITS-1:0]      res_cnt
);

    typedef struct packed {
        scan_state_t st;
        logic        ev;
        logic        again;
        out_item_t   tok;
    } pass_t;

    function automatic logic is_space(input logic [7:0] c);
        return c == CH_SPACE || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_hspace(input logic [7:0] c);
        return is_space(c) && c != CH_NL;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_start(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_US;
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_start(c) || is_digit(c);
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        return (v == OFF_MAX) ? v : v + OFFSET_BITS'(1);
    endfunction

    function automatic out_item_t mk_tok(input logic [3:0] k, input logic [3:0] er,
                                         input logic [OFFSET_BITS-1:0] s,
                                         input logic [OFFSET_BITS-1:0] e,
                                         input logic [LINE_BITS-1:0] ln,
                                         input logic [COLUMN_BITS-1:0] col);
        out_item_t t;
        t.token_kind    = k;
        t.error_code    = er;
        t.start_offset  = s;
        t.end_offset    = e;
        t.line_number   = ln;
        t.column_number = col;
        t.run_last      = 1'b0;
        return t;
    endfunction

    // one trip through the mode switch; again asks for the byte to be rescanned
    function automatic pass_t scan_pass(input scan_state_t st, input logic [7:0] c);
        pass_t r;
        logic [OFFSET_BITS-1:0] content;
        logic [OFFSET_BITS-1:0] p;
        r.st    = st;
        r.ev    = 1'b0;
        r.again = 1'b0;
        r.tok   = '0;
        p       = st.offset;
        content = sat_off(st.tok_off);
        unique case (st.mode)
            MODE_IDLE: begin
                if (!is_space(c)) begin
                    r.st.tok_off  = p;
                    r.st.tok_line = st.line;
                    r.st.tok_col  = st.column;
                    content = sat_off(p);
                    priority if (c == CH_HASH) begin
                        r.st.mode = MODE_HASH;
                    end else if (c == CH_SLASH) begin
                        r.st.mode = MODE_SLASH;
                    end else if (c == CH_DQ || c == CH_SQ) begin
                        r.st.quote_dbl = (c == CH_DQ);
                        r.st.esc_pend  = 1'b0;
                        r.st.mode      = MODE_QUOTE;
                    end else if (is_start(c)) begin
                        r.st.mode = MODE_IDENT;
                    end else if (is_digit(c)) begin
                        r.st.mode = MODE_NUMBER;
                    end else begin
                        r.ev  = 1'b1;
                        r.tok = mk_tok(KIND_PUNCT, ERR_NONE, p, content, st.line, st.column);
                    end
                end
            end
            MODE_IDENT, MODE_NUMBER: begin
                if (!is_word(c)) begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok((st.mode == MODE_IDENT) ? KIND_IDENT : KIND_NUMBER,
                                   ERR_NONE, st.tok_off, p, st.tok_line, st.tok_col);
                    r.st.mode = MODE_IDLE;
                    r.again   = 1'b1;
                end
            end
            MODE_SLASH: begin
                priority if (c == CH_STAR) begin
                    r.st.mode      = MODE_BLOCK_CMT;
                    r.st.star_seen = 1'b0;
                end else if (c == CH_SLASH) begin
                    r.st.mode = MODE_LINE_CMT;
                end else begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok(KIND_PUNCT, ERR_NONE, st.tok_off, content,
                                   st.tok_line, st.tok_col);
                    r.st.mode = MODE_IDLE;
                    r.again   = 1'b1;
                end
            end
            MODE_LINE_CMT: begin
                if (c == CH_NL) r.st.mode = MODE_IDLE;
            end
            MODE_BLOCK_CMT: begin
                if (st.star_seen && c == CH_SLASH) begin
                    r.st.mode      = MODE_IDLE;
                    r.st.star_seen = 1'b0;
                end else begin
                    r.st.star_seen = (c == CH_STAR);
                end
            end
            MODE_HASH: begin
                priority if (is_hspace(c)) begin
                    r.st.mode = MODE_HASH;
                end else if (is_start(c)) begin
                    r.st.tok_off   = p;
                    r.st.tok_line  = st.line;
                    r.st.tok_col   = st.column;
                    r.st.dir_match = (c == include_char(4'd0)) ? 4'd1 : MATCH_FAIL;
                    r.st.mode      = MODE_DIRECTIVE;
                end else begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok(KIND_PUNCT, ERR_NONE, st.tok_off, p,
                                   st.tok_line, st.tok_col);
                    r.st.mode = MODE_IDLE;
                    r.again   = 1'b1;
                end
            end
            MODE_DIRECTIVE: begin
                if (is_word(c)) begin
                    r.st.dir_match = (st.dir_match < MATCH_DONE &&
                                      c == include_char(st.dir_match)) ?
                                     st.dir_match + 4'd1 : MATCH_FAIL;
                end else begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok(KIND_DIRECTIVE, ERR_NONE, st.tok_off, p,
                                   st.tok_line, st.tok_col);
                    if (st.dir_match == MATCH_DONE) begin
                        r.st.include_mode = 1'b1;
                        r.st.mode         = MODE_HDR_WAIT;
                    end else begin
                        r.st.mode = MODE_IDLE;
                    end
                    r.st.dir_match = 4'd0;
                    r.again        = 1'b1;
                end
            end
            MODE_QUOTE: begin
                priority if (st.esc_pend) begin
                    r.st.esc_pend = 1'b0;
                end else if (c == CH_BSL) begin
                    r.st.esc_pend = 1'b1;
                end else if (c == CH_NL) begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok(KIND_ERROR, st.quote_dbl ? ERR_OPEN_STRING : ERR_OPEN_CHAR,
                                   st.tok_off, p, st.tok_line, st.tok_col);
                    r.st.mode = MODE_IDLE;
                end else if (c == (st.quote_dbl ? CH_DQ : CH_SQ)) begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok(st.quote_dbl ? KIND_STRING : KIND_CHAR, ERR_NONE,
                                   content, p, st.tok_line, st.tok_col);
                    r.st.mode = MODE_IDLE;
                end else begin
                    r.st.esc_pend = 1'b0;
                end
            end
            MODE_HDR_WAIT: begin
                priority if (is_hspace(c)) begin
                    r.st.mode = MODE_HDR_WAIT;
                end else if (c == CH_LT || c == CH_DQ) begin
                    r.st.tok_off   = p;
                    r.st.tok_line  = st.line;
                    r.st.tok_col   = st.column;
                    r.st.quote_dbl = (c == CH_DQ);
                    r.st.mode      = MODE_HDR_BODY;
                end else if (c == CH_NL) begin
                    r.st.include_mode = 1'b0;
                    r.ev  = 1'b1;
                    r.tok = mk_tok(KIND_ERROR, ERR_NO_HEADER, p, p, st.line, st.column);
                    r.st.mode = MODE_IDLE;
                end else begin
                    r.st.include_mode = 1'b0;
                    r.st.tok_off  = p;
                    r.st.tok_line = st.line;
                    r.st.tok_col  = st.column;
                    r.st.mode     = MODE_SKIP_NONE;
                end
            end
            MODE_HDR_BODY: begin
                priority if (c == (st.quote_dbl ? CH_DQ : CH_GT)) begin
                    r.st.hdr_end = p;
                    r.st.mode    = MODE_HDR_TAIL;
                end else if (c == CH_NL) begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok(KIND_ERROR, ERR_EOL_HEADER, st.tok_off, p,
                                   st.tok_line, st.tok_col);
                    r.st.include_mode = 1'b0;
                    r.st.mode         = MODE_IDLE;
                end else begin
                    r.st.mode = MODE_HDR_BODY;
                end
            end
            MODE_HDR_TAIL: begin
                if (!is_hspace(c)) begin
                    r.st.include_mode = 1'b0;
                    if (c == CH_NL) begin
                        r.ev  = 1'b1;
                        r.tok = mk_tok(KIND_HEADER, ERR_NONE, content, st.hdr_end,
                                       st.tok_line, st.tok_col);
                        r.st.mode = MODE_IDLE;
                    end else begin
                        r.st.mode = MODE_SKIP_AFTER;
                    end
                end
            end
            MODE_SKIP_AFTER, MODE_SKIP_NONE: begin
                if (c == CH_NL) begin
                    r.ev  = 1'b1;
                    r.tok = mk_tok(KIND_ERROR,
                                   (st.mode == MODE_SKIP_AFTER) ? ERR_AFTER_HEADER : ERR_NO_HEADER,
                                   st.tok_off, p, st.tok_line, st.tok_col);
                    r.st.mode = MODE_IDLE;
                end
            end
            default: begin
                r.st.mode = MODE_IDLE;
                r.again   = 1'b1;
            end
        endcase
        return r;
    endfunction

    pass_t                  p1;
    pass_t                  p2;
    scan_state_t            st_a;
    scan_state_t            st_b;
    out_item_t              cand [CAND_COUNT];
    logic [CAND_COUNT-1:0]  cand_v;
    logic [OFFSET_BITS-1:0] fe;
    logic [OFFSET_BITS-1:0] fcontent;

    always_comb begin
        p1 = scan_pass(cur_state, item.char_byte);
        p2 = scan_pass(p1.st, item.char_byte);
        st_a = p1.again ? p2.st : p1.st;

        // counters after the byte
        st_b = st_a;
        st_b.offset = sat_off(cur_state.offset);
        if (item.char_byte == CH_NL) begin
            st_b.line = (cur_state.line == LINE_MAX) ? cur_state.line
                                                     : cur_state.line + LINE_BITS'(1);
            st_b.column       = COLUMN_BITS'(1);
            st_b.include_mode = 1'b0;
        end else begin
            st_b.column = (cur_state.column == COL_MAX) ? cur_state.column
                                                        : cur_state.column + COLUMN_BITS'(1);
        end

        cand_v  = '0;
        cand[0] = p1.tok;
        cand[1] = p2.tok;
        cand[2] = '0;
        cand[3] = '0;
        cand[4] = '0;
        cand_v[0] = p1.ev;
        cand_v[1] = p1.again && p2.ev;

        // end of source: flush the open token, then end of file
        fe       = st_b.offset;
        fcontent = sat_off(st_b.tok_off);
        if (item.final_byte) begin
            cand_v[2] = 1'b1;
            unique case (st_b.mode)
                MODE_IDENT:
                    cand[2] = mk_tok(KIND_IDENT, ERR_NONE, st_b.tok_off, fe,
                                     st_b.tok_line, st_b.tok_col);
                MODE_NUMBER:
                    cand[2] = mk_tok(KIND_NUMBER, ERR_NONE, st_b.tok_off, fe,
                                     st_b.tok_line, st_b.tok_col);
                MODE_SLASH:
                    cand[2] = mk_tok(KIND_PUNCT, ERR_NONE, st_b.tok_off, fcontent,
                                     st_b.tok_line, st_b.tok_col);
                MODE_HASH:
                    cand[2] = mk_tok(KIND_PUNCT, ERR_NONE, st_b.tok_off, fe,
                                     st_b.tok_line, st_b.tok_col);
                MODE_DIRECTIVE: begin
                    cand[2] = mk_tok(KIND_DIRECTIVE, ERR_NONE, st_b.tok_off, fe,
                                     st_b.tok_line, st_b.tok_col);
                    cand_v[3] = (st_b.dir_match == MATCH_DONE);
                    cand[3] = mk_tok(KIND_ERROR, ERR_NO_HEADER, fe, fe, st_b.line, st_b.column);
                end
                MODE_QUOTE:
                    cand[2] = mk_tok(KIND_ERROR, st_b.esc_pend ? ERR_BAD_ESCAPE :
                                     (st_b.quote_dbl ? ERR_EOF_STRING : ERR_EOF_CHAR),
                                     fcontent, fe, st_b.tok_line, st_b.tok_col);
                MODE_HDR_WAIT:
                    cand[2] = mk_tok(KIND_ERROR, ERR_NO_HEADER, fe, fe, st_b.line, st_b.column);
                MODE_HDR_BODY:
                    cand[2] = mk_tok(KIND_ERROR, ERR_EOF_HEADER, st_b.tok_off, fe,
                                     st_b.tok_line, st_b.tok_col);
                MODE_HDR_TAIL:
                    cand[2] = mk_tok(KIND_HEADER, ERR_NONE, fcontent, st_b.hdr_end,
                                     st_b.tok_line, st_b.tok_col);
                MODE_SKIP_AFTER:
                    cand[2] = mk_tok(KIND_ERROR, ERR_AFTER_HEADER, st_b.tok_off, fe,
                                     st_b.tok_line, st_b.tok_col);
                MODE_SKIP_NONE:
                    cand[2] = mk_tok(KIND_ERROR, ERR_NO_HEADER, st_b.tok_off, fe,
                                     st_b.tok_line, st_b.tok_col);
                default:
                    cand_v[2] = 1'b0;
            endcase
            cand_v[4] = 1'b1;
            cand[4] = mk_tok(KIND_EOF, ERR_NONE, fe, fe, st_b.line, st_b.column);
            nxt_state = reset_state();
        end else begin
            nxt_state = st_b;
        end

        // pack the emitted tokens in order, keeping the first four
        for (int i = 0; i < MAX_RESULTS; i++) res[i] = '0;
        res_cnt = '0;
        for (int i = 0; i < CAND_COUNT; i++) begin
            if (cand_v[i] && res_cnt < CNT_BITS'(MAX_RESULTS)) begin
                res[res_cnt[IDX_BITS-1:0]] = cand[i];
                res_cnt = res_cnt + CNT_BITS'(1);
            end
        end
    end

endmodule

[hw/rtl/preprocessor_token_scanner_core.sv]
// top level: input register, scanner state, result buffer and output handshake
// flow: a byte accepted into the input register is scanned when the result buffer can take
//   its tokens, which are loaded there and then presented on m_data in order
// throughput: one byte per cycle while each byte yields at most one token and m_ready stays
//   high; a byte with more tokens holds the input while the four-entry buffer drains
// reset: aresetn low at a clock edge empties both registers and restores the scanner
module preprocessor_token_scanner_core import tsc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic                  in_v_reg, in_v_next;
    in_item_t              in_data_reg;
    scan_state_t           state_reg, state_next;
    out_item_t             res_reg [MAX_RESULTS];
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [IDX_BITS-1:0]   idx_reg, idx_next;

    out_item_t             scan_res [MAX_RESULTS];
    logic [CNT_BITS-1:0]   scan_cnt;
    logic                  last_out;
    logic                  out_take;
    logic                  consume;

    tsc_scan u_scan (
        .cur_state (state_reg),
        .item      (in_data_reg),
        .nxt_state (state_next),
        .res       (scan_res),
        .res_cnt   (scan_cnt)
    );

    assign m_valid  = (cnt_reg != '0);
    assign last_out = ({1'b0, idx_reg} == cnt_reg - CNT_BITS'(1));
    assign out_take = m_valid && m_ready;
    // the buffer can take new tokens when it is empty or once its last one leaves
    assign consume  = in_v_reg && (!m_valid || (out_take && last_out));
    assign s_ready  = !in_v_reg || consume;

    always_comb begin
        m_data          = res_reg[idx_reg];
        m_data.run_last = last_out;
    end

    always_comb begin
        in_v_next = in_v_reg;
        if (s_valid && s_ready) begin
            in_v_next = 1'b1;
        end else if (consume) begin
            in_v_next = 1'b0;
        end
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        if (consume) begin
            cnt_next = scan_cnt;
            idx_next = '0;
        end else if (out_take) begin
            if (last_out) begin
                cnt_next = '0;
                idx_next = '0;
            end else begin
                idx_next = idx_reg + IDX_BITS'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg  <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            state_reg <= reset_state();
        end else begin
            in_v_reg <= in_v_next;
            cnt_reg  <= cnt_next;
            idx_reg  <= idx_next;
            if (consume) state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) in_data_reg <= s_data;
        if (consume) begin
            for (int i = 0; i < MAX_RESULTS; i++) res_reg[i] <= scan_res[i];
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_BITS'(MAX_RESULTS))
        else $error("result count out of range");

    a_idx_below_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, idx_reg} < cnt_reg))
        else $error("result index past count");

    a_hold_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_v_reg && !consume) |=> (in_v_reg && $stable(in_data_reg)))
        else $error("pending byte lost");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (consume && scan_cnt != '0) |=> (m_valid && idx_reg == '0))
        else $error("tokens not presented");

endmodule
